>>> rtl/tsb_pkg.sv
package tsb_pkg;

    localparam int BYTE_W  = 8;
    localparam int CODE_W  = 24;
    localparam int COUNT_W = 25;
    localparam int ADDR_W  = 3;
    localparam int DATA_W  = 32;

    localparam logic [COUNT_W-1:0] COUNT_MAX   = 25'h1FF_FFFF;
    localparam logic [COUNT_W-1:0] LIMIT_RESET = 25'd20000;

    // Register index, taken from paddr[2] (byte address 4*i).
    localparam logic REG_LIMIT = 1'b0;

    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = 2;
    localparam int Q_CNT_W = 3;

    typedef struct packed {
        logic              command;
        logic [BYTE_W-1:0] byte_value;
    } in_item_t;

    typedef struct packed {
        logic               trigram_valid;
        logic [CODE_W-1:0]  trigram_code;
        logic               is_new;
        logic [COUNT_W-1:0] distinct_count;
        logic               binary_flag;
    } out_item_t;

    typedef enum logic [1:0] {
        OP_START,
        OP_SHIFT,
        OP_TRIGRAM
    } op_kind_t;

    typedef struct packed {
        op_kind_t          kind;
        logic [CODE_W-1:0] code;
    } op_t;

endpackage

>>> rtl/tsb_front.sv
module tsb_front
    import tsb_pkg::*;
#(
    parameter int SYMBOL_BITS = 8
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     item_valid,
    output logic     item_stall,
    input  in_item_t item,
    input  logic     push_ready,
    output logic     push_valid,
    output op_t      push_op
);

    logic [2*SYMBOL_BITS-1:0] window_reg;
    logic [2*SYMBOL_BITS-1:0] window_next;
    logic [1:0]               seen_reg;
    logic [1:0]               seen_next;
    logic [SYMBOL_BITS-1:0]   sym;
    logic                     accept;

    assign item_stall = !push_ready;
    assign accept     = item_valid && push_ready;
    assign push_valid = accept;
    assign sym        = item.byte_value[SYMBOL_BITS-1:0];

    // The window is shifted even after the file turns binary; the back end
    // drops those bytes, and the next start command clears the window.
    always_comb
    begin
        window_next  = window_reg;
        seen_next    = seen_reg;
        push_op.kind = OP_SHIFT;
        push_op.code = '0;
        if (item.command)
        begin
            push_op.kind = OP_START;
            window_next  = '0;
            seen_next    = '0;
        end
        else
        begin
            window_next = {window_reg[SYMBOL_BITS-1:0], sym};
            if (seen_reg >= 2'd2)
            begin
                push_op.kind = OP_TRIGRAM;
                push_op.code = CODE_W'({window_reg, sym});
            end
            else
            begin
                seen_next = seen_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= '0;
            seen_reg   <= '0;
        end
        else if (accept)
        begin
            window_reg <= window_next;
            seen_reg   <= seen_next;
        end
    end

endmodule

>>> rtl/tsb_queue.sv
module tsb_queue
    import tsb_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push_valid,
    output logic push_ready,
    input  op_t  push_op,
    output logic pop_valid,
    input  logic pop,
    output op_t  pop_op
);

    op_t                slot_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] head_reg;
    logic [Q_PTR_W-1:0] tail_reg;
    logic [Q_CNT_W-1:0] count_reg;
    logic               do_push;
    logic               do_pop;

    assign push_ready = (count_reg != Q_CNT_W'(Q_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_op     = slot_reg[head_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[tail_reg] <= push_op;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (do_push)
            begin
                tail_reg <= tail_reg + Q_PTR_W'(1);
            end
            if (do_pop)
            begin
                head_reg <= head_reg + Q_PTR_W'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + Q_CNT_W'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - Q_CNT_W'(1);
            end
        end
    end

endmodule

>>> rtl/tsb_back.sv
module tsb_back
    import tsb_pkg::*;
#(
    parameter int SYMBOL_BITS = 8
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [COUNT_W-1:0] limit,
    input  logic               pop_valid,
    input  op_t                pop_op,
    output logic               pop,
    output logic               result_valid,
    input  logic               result_stall,
    output out_item_t          result
);

    localparam int CODE_BITS = 3 * SYMBOL_BITS;
    localparam int LANE_BITS = (CODE_BITS > 6) ? 6 : CODE_BITS - 1;
    localparam int ROW_BITS  = CODE_BITS - LANE_BITS;
    localparam int ROW_W     = 1 << LANE_BITS;
    localparam int ROWS      = 1 << ROW_BITS;

    typedef enum logic {
        ST_CLEAR,
        ST_RUN
    } state_t;

    logic [ROW_W-1:0]    mem [ROWS];

    state_t              state_reg;
    logic [ROW_BITS-1:0] clr_addr_reg;
    logic                b_valid_reg;
    op_t                 b_op_reg;
    logic [ROW_W-1:0]    rd_row_reg;
    logic                fwd_valid_reg;
    logic [ROW_BITS-1:0] fwd_addr_reg;
    logic [ROW_W-1:0]    fwd_data_reg;
    logic [COUNT_W-1:0]  count_reg;
    logic [COUNT_W-1:0]  count_next;
    logic                over_reg;
    logic                over_next;
    logic                out_valid_reg;
    out_item_t           out_item_reg;
    out_item_t           out_item_next;

    logic [CODE_BITS-1:0] b_code;
    logic [ROW_BITS-1:0]  b_row;
    logic [LANE_BITS-1:0] b_lane;
    logic [ROW_BITS-1:0]  rd_addr;
    logic [ROW_W-1:0]     row_cur;
    logic                 b_adv;
    logic                 b_is_start;
    logic                 do_insert;
    logic                 fresh;
    logic                 mem_we;
    logic [ROW_BITS-1:0]  mem_waddr;
    logic [ROW_W-1:0]     mem_wdata;
    logic [ROW_W-1:0]     row_set;

    assign b_code     = b_op_reg.code[CODE_BITS-1:0];
    assign b_row      = b_code[CODE_BITS-1:LANE_BITS];
    assign b_lane     = b_code[LANE_BITS-1:0];
    assign rd_addr    = pop_op.code[CODE_BITS-1:LANE_BITS];

    // The row written by the previous insert may not have reached the
    // registered read yet, so it is forwarded.
    assign row_cur    = (fwd_valid_reg && (fwd_addr_reg == b_row)) ? fwd_data_reg : rd_row_reg;
    assign row_set    = row_cur | (ROW_W'(1) << b_lane);

    assign b_adv      = b_valid_reg && (!out_valid_reg || !result_stall);
    assign b_is_start = b_valid_reg && (b_op_reg.kind == OP_START);
    assign do_insert  = (b_op_reg.kind == OP_TRIGRAM) && !over_reg;
    assign fresh      = do_insert && !row_cur[b_lane];

    assign pop = pop_valid && (state_reg == ST_RUN) && !b_is_start
                 && (!b_valid_reg || b_adv);

    assign mem_we    = (state_reg == ST_CLEAR) || (b_adv && fresh);
    assign mem_waddr = (state_reg == ST_CLEAR) ? clr_addr_reg : b_row;
    assign mem_wdata = (state_reg == ST_CLEAR) ? '0 : row_set;

    always_comb
    begin
        count_next = count_reg;
        if (fresh && (count_reg != COUNT_MAX))
        begin
            count_next = count_reg + COUNT_W'(1);
        end
        over_next = over_reg || (do_insert && (count_next > limit));
    end

    always_comb
    begin
        out_item_next = '0;
        case (b_op_reg.kind)
            OP_START:
            begin
                out_item_next = '0;
            end
            OP_TRIGRAM:
            begin
                out_item_next.distinct_count = count_next;
                out_item_next.binary_flag    = over_next;
                if (do_insert)
                begin
                    out_item_next.trigram_valid = 1'b1;
                    out_item_next.trigram_code  = CODE_W'(b_code);
                    out_item_next.is_new        = fresh;
                end
            end
            default:
            begin
                out_item_next.distinct_count = count_reg;
                out_item_next.binary_flag    = over_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (pop)
        begin
            rd_row_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            b_op_reg <= pop_op;
        end
        if (b_adv)
        begin
            out_item_reg <= out_item_next;
        end
        if (b_adv && fresh)
        begin
            fwd_addr_reg <= b_row;
            fwd_data_reg <= row_set;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_addr_reg  <= '0;
            b_valid_reg   <= 1'b0;
            fwd_valid_reg <= 1'b0;
            count_reg     <= '0;
            over_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (state_reg == ST_CLEAR)
            begin
                fwd_valid_reg <= 1'b0;
                clr_addr_reg  <= clr_addr_reg + ROW_BITS'(1);
                if (&clr_addr_reg)
                begin
                    state_reg <= ST_RUN;
                end
            end

            if (pop)
            begin
                b_valid_reg <= 1'b1;
            end
            else if (b_adv)
            begin
                b_valid_reg <= 1'b0;
            end

            if (b_adv)
            begin
                if (b_op_reg.kind == OP_START)
                begin
                    count_reg     <= '0;
                    over_reg      <= 1'b0;
                    state_reg     <= ST_CLEAR;
                    clr_addr_reg  <= '0;
                    fwd_valid_reg <= 1'b0;
                end
                else
                begin
                    count_reg <= count_next;
                    over_reg  <= over_next;
                    if (fresh)
                    begin
                        fwd_valid_reg <= 1'b1;
                    end
                end
            end

            if (b_adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_item_reg;

endmodule

>>> rtl/trigram_set_builder_core.sv
// Trigram set builder: marks every three-byte window of a file in a
// presence bitmap and counts the distinct trigrams.
//
// Input channel (item_valid / item_stall / item): one transaction per file
// byte, or a start command that opens a new file and clears the set.
// Output channel (result_valid / result_stall / result): exactly one
// transaction per input transaction, in order. A result carries the
// trigram, whether it was new, the distinct count and the binary flag.
//
// Throughput is one transaction per cycle unless a stall or clear pass holds it:
// the bitmap is read and written once per byte, and a forwarded copy of the last
// written row covers back to back hits on the same row. A result passes a queue
// slot, the back-end register and the output register. A stalled output holds its
// transaction while the four-entry queue keeps taking input until it fills.
//
// After reset and after each start command the bitmap is cleared one row
// per cycle, 2**(3*SYMBOL_BITS-6) rows (262144 at SYMBOL_BITS = 8); no
// byte leaves the queue during that pass. trigram_limit resets to 20000
// and is written over the APB port at byte address 0.
module trigram_set_builder_core
    import tsb_pkg::*;
#(
    parameter int SYMBOL_BITS = 8
)
(
    input  logic              clk,
    input  logic              rst_n,

    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,

    input  logic              item_valid,
    output logic              item_stall,
    input  in_item_t          item,

    output logic              result_valid,
    input  logic              result_stall,
    output out_item_t         result
);

    logic [COUNT_W-1:0] limit_reg;
    logic               q_push_valid;
    logic               q_push_ready;
    op_t                q_push_op;
    logic               q_pop_valid;
    logic               q_pop;
    op_t                q_pop_op;

    // The register index is the word address; the low two bits select a
    // byte inside the word and are not decoded.
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_LIMIT) ? DATA_W'(limit_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= LIMIT_RESET;
        end
        else if (psel && penable && pwrite && (paddr[2] == REG_LIMIT))
        begin
            limit_reg <= pwdata[COUNT_W-1:0];
        end
    end

    // The front end tracks the byte window and classifies each
    // transaction; the back end owns the bitmap, the count and the flag.
    tsb_front #(
        .SYMBOL_BITS (SYMBOL_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .push_ready (q_push_ready),
        .push_valid (q_push_valid),
        .push_op    (q_push_op)
    );

    tsb_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (q_push_valid),
        .push_ready (q_push_ready),
        .push_op    (q_push_op),
        .pop_valid  (q_pop_valid),
        .pop        (q_pop),
        .pop_op     (q_pop_op)
    );

    tsb_back #(
        .SYMBOL_BITS (SYMBOL_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .limit        (limit_reg),
        .pop_valid    (q_pop_valid),
        .pop_op       (q_pop_op),
        .pop          (q_pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

>>> rtl/tsb_checker.sv
module tsb_checker
    import tsb_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      result_valid,
    input logic      result_stall,
    input out_item_t result
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("stalled result changed or dropped");

    a_new_is_valid: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.is_new |-> result.trigram_valid)
        else $error("new trigram reported without a trigram");

    a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.trigram_valid |->
            (result.trigram_code == '0) && !result.is_new)
        else $error("result without a trigram carries a code");

    a_new_counts: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.is_new |-> (result.distinct_count != '0))
        else $error("new trigram left the distinct count at zero");

    a_reset_idle: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !result_valid)
        else $error("result shown right after reset");

endmodule

bind trigram_set_builder_core tsb_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);
